// ===== design/tdpc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the trial division prime counter.
// Widths, job class codes and the front-to-back job type; no dependencies.
package tdpc_pkg;

    localparam int VALUE_W   = 24;
    localparam int TALLY_W   = 24;
    localparam int DIV_W     = VALUE_W / 2 + 1;
    localparam int SQ_W      = 2 * DIV_W;
    localparam int BIT_W     = $clog2(VALUE_W);
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    localparam logic [1:0] CLS_COMPOSITE = 2'd0;
    localparam logic [1:0] CLS_PRIME     = 2'd1;
    localparam logic [1:0] CLS_TEST      = 2'd2;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [TALLY_W-1:0] t_tally;

    typedef struct packed {
        logic       valid;
        logic [1:0] cls;
        t_value     value;
    } t_job;

endpackage

// ===== design/tdpc_if.sv =====
`timescale 1ns / 1ps
// Request channels of the trial division prime counter: candidates in, results out.
// Depends on tdpc_pkg.
interface tdpc_in_if;
    import tdpc_pkg::*;
    logic   valid;
    logic   ready;
    t_value candidate_value;
    modport source (output valid, output candidate_value, input ready);
    modport sink   (input valid, input candidate_value, output ready);
endinterface

interface tdpc_out_if;
    import tdpc_pkg::*;
    logic   valid;
    logic   ready;
    logic   is_prime;
    t_tally prime_total;
    modport source (output valid, output is_prime, output prime_total, input ready);
    modport sink   (input valid, input is_prime, input prime_total, output ready);
endinterface

// ===== design/tdpc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts candidates, classifies them and queues jobs for the back end.
// Depends on tdpc_pkg and tdpc_if.
module tdpc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tdpc_in_if.sink       i_cand,
    output tdpc_pkg::t_job o_job,
    input  logic          i_pop
);
    import tdpc_pkg::*;

    logic [1:0]         r_cls  [Q_DEPTH];
    t_value             r_val  [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_PTR_W:0]   r_count, n_count;
    logic               push;
    logic               pop;
    logic [1:0]         cls;
    t_value             n;

    assign i_cand.ready = (r_count != Q_PTR_W'(0) + (Q_PTR_W+1)'(Q_DEPTH));
    assign push = i_cand.valid & i_cand.ready;
    assign pop  = i_pop & (r_count != '0);
    assign n    = i_cand.candidate_value;

    always_comb begin
        if (n < t_value'(2)) begin
            cls = CLS_COMPOSITE;
        end else if (n < t_value'(4)) begin
            cls = CLS_PRIME;
        end else if (!n[0]) begin
            cls = CLS_COMPOSITE;
        end else begin
            cls = CLS_TEST;
        end
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_cls[r_wr_ptr] <= cls;
            r_val[r_wr_ptr] <= n;
        end
    end

    assign o_job.valid = (r_count != '0);
    assign o_job.cls   = r_cls[r_rd_ptr];
    assign o_job.value = r_val[r_rd_ptr];

endmodule

// ===== design/tdpc_back.sv =====
`timescale 1ns / 1ps
// Back end: trial division over odd divisors with a bit-serial remainder unit,
// prime tally and output register. Depends on tdpc_pkg and tdpc_if.
module tdpc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tdpc_pkg::t_job i_job,
    output logic           o_pop,
    tdpc_out_if.source     o_res
);
    import tdpc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       r_state, n_state;
    t_value           r_n, n_n;
    logic [DIV_W-1:0] r_d, n_d;
    logic [SQ_W-1:0]  r_sq, n_sq;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_prime, n_prime;
    t_tally           r_tally, n_tally;
    logic             r_valid, n_valid;
    logic             r_out_prime, n_out_prime;
    t_tally           r_total, n_total;

    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_sub;
    logic [DIV_W-1:0] rem_new;
    logic             out_free;

    assign out_free = !r_valid || o_res.ready;
    assign rem_sh   = {r_rem, r_n[r_bit]};
    assign rem_sub  = rem_sh - {1'b0, r_d};
    assign rem_new  = (rem_sh >= {1'b0, r_d}) ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_d         = r_d;
        n_sq        = r_sq;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_prime     = r_prime;
        n_tally     = r_tally;
        n_valid     = r_valid && !o_res.ready;
        n_out_prime = r_out_prime;
        n_total     = r_total;
        o_pop       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job.valid) begin
                    o_pop   = 1'b1;
                    n_n     = i_job.value;
                    n_d     = DIV_W'(3);
                    n_sq    = SQ_W'(9);
                    n_prime = (i_job.cls == CLS_PRIME);
                    n_state = (i_job.cls == CLS_TEST) ? ST_CHECK : ST_DONE;
                end
            end
            ST_CHECK: begin
                if (r_sq > SQ_W'(r_n)) begin
                    n_prime = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_rem   = '0;
                    n_bit   = BIT_W'(VALUE_W - 1);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem = rem_new;
                if (r_bit == '0) begin
                    if (rem_new == '0) begin
                        n_prime = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_d     = r_d + DIV_W'(2);
                        n_sq    = r_sq + SQ_W'({r_d, 2'b00}) + SQ_W'(4);
                        n_state = ST_CHECK;
                    end
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (r_prime && r_tally != TALLY_MAX) begin
                        n_tally = r_tally + t_tally'(1);
                    end
                    n_valid     = 1'b1;
                    n_out_prime = r_prime;
                    n_total     = n_tally;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tally <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tally <= n_tally;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_d         <= n_d;
        r_sq        <= n_sq;
        r_rem       <= n_rem;
        r_bit       <= n_bit;
        r_prime     <= n_prime;
        r_out_prime <= n_out_prime;
        r_total     <= n_total;
    end

    assign o_res.valid       = r_valid;
    assign o_res.is_prime    = r_out_prime;
    assign o_res.prime_total = r_total;

endmodule

// ===== design/trial_division_prime_counter.sv =====
`timescale 1ns / 1ps
// Trial division prime counter: one result (prime flag, running prime count) per
// candidate. The front end classifies values below 4 and even values at once and
// queues up to four jobs; the back end tests odd candidates of 5 and up against
// divisors 3, 5, 7, ... while the divisor squared does not exceed the candidate,
// using a remainder unit that takes one candidate bit per cycle. A classified item
// passes the back end through its idle and done states; an odd candidate also
// takes a check state and a divide pass for each divisor tried (at most about
// 2048 for a prime near 2^24). The prime count saturates at 16777215.
// Depends on tdpc_pkg, tdpc_if, tdpc_front and tdpc_back.
module trial_division_prime_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdpc_in_if.sink     i_cand,
    tdpc_out_if.source  o_res
);
    import tdpc_pkg::*;

    t_job job;
    logic pop;

    tdpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (i_cand),
        .o_job   (job),
        .i_pop   (pop)
    );

    tdpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ===== sim/tdpc_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the trial division prime counter: watches both request channels,
// predicts prime flag and running count per accepted candidate, compares in order.
// Depends on tdpc_pkg.
module tdpc_result_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cand_valid,
    input  logic             i_cand_ready,
    input  tdpc_pkg::t_value i_cand_value,
    input  logic             i_res_valid,
    input  logic             i_res_ready,
    input  logic             i_res_is_prime,
    input  tdpc_pkg::t_tally i_res_total,
    output int               o_pending,
    output int               o_fail_count
);
    import tdpc_pkg::*;

    typedef struct packed {
        logic   is_prime;
        t_tally total;
    } t_verdict;

    t_verdict awaited_verdicts [$];
    t_tally   model_tally;
    t_verdict want;
    logic     cand_prime;
    int       fails;

    function automatic logic trial_div_prime(input t_value n);
        longint unsigned v;
        longint unsigned d;
        v = 64'(n);
        if (v < 2) return 1'b0;
        for (d = 2; d * d <= v && d <= v / 2; d++) begin
            if (v % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_verdicts.delete();
            model_tally = '0;
            fails       = 0;
        end else begin
            // result side first: a candidate accepted this edge cannot answer this edge
            if (i_res_valid && i_res_ready) begin
                if (awaited_verdicts.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual is_prime %0d total %0d",
                             $time, i_res_is_prime, i_res_total);
                    fails++;
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (i_res_is_prime !== want.is_prime) begin
                        $display("%0t is_prime mismatch: expected %0d actual %0d",
                                 $time, want.is_prime, i_res_is_prime);
                        fails++;
                    end
                    if (i_res_total !== want.total) begin
                        $display("%0t prime_total mismatch: expected %0d actual %0d",
                                 $time, want.total, i_res_total);
                        fails++;
                    end
                end
            end
            if (i_cand_valid && i_cand_ready) begin
                cand_prime = trial_div_prime(i_cand_value);
                if (cand_prime && model_tally != TALLY_MAX) model_tally++;
                awaited_verdicts.push_back('{is_prime: cand_prime, total: model_tally});
            end
        end
        o_pending    = awaited_verdicts.size();
        o_fail_count = fails;
    end

endmodule

// ===== sim/tb_trial_division_prime_counter.sv =====
`timescale 1ns / 1ps
// Testbench top for the trial division prime counter: clock, reset, candidate stimulus,
// result back-pressure and the verdict. Depends on tdpc_pkg, tdpc_if, the block and
// tdpc_result_checker.
module tb_trial_division_prime_counter;
    import tdpc_pkg::*;

    localparam int CYCLE_LIMIT  = 8000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int N_PHASES     = 10;
    localparam int PHASE_ITEMS  = 100;
    localparam int N_CORNERS    = 25;

    logic i_clk;
    logic i_rst_n;
    int   cycle_cnt;
    int   pending_cnt;
    int   fail_cnt;
    bit   send_burst;
    bit   recv_burst;
    bit   hold_req;

    // small values, primes and squares at the loop bound, top bit, largest prime, slow semiprime
    t_value corner_vals [N_CORNERS] = '{
        24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd6, 24'd7, 24'd8, 24'd9,
        24'd11, 24'd25, 24'd49, 24'd121, 24'd97, 24'd1023, 24'd1024, 24'd65521,
        24'd65537, 24'd8388608, 24'd8388607, 24'd16777215, 24'd16777213,
        24'd16752649, 24'd12345678
    };

    tdpc_in_if  cand_if ();
    tdpc_out_if res_if ();

    trial_division_prime_counter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (cand_if),
        .o_res   (res_if)
    );

    tdpc_result_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cand_valid   (cand_if.valid),
        .i_cand_ready   (cand_if.ready),
        .i_cand_value   (cand_if.candidate_value),
        .i_res_valid    (res_if.valid),
        .i_res_ready    (res_if.ready),
        .i_res_is_prime (res_if.is_prime),
        .i_res_total    (res_if.prime_total),
        .o_pending      (pending_cnt),
        .o_fail_count   (fail_cnt)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 12));
    endfunction

    // mostly short candidates; wide ones are rare since a large prime is slow to test
    function automatic t_value pick_cand(input bit short_only);
        int r;
        r = $urandom_range(0, 99);
        if (short_only || r >= 24) return t_value'($urandom_range(0, 1023));
        if (r >= 2) return t_value'($urandom_range(0, 16383));
        return t_value'($urandom);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_cand(input t_value v);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            cand_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cand_if.valid           <= 1'b1;
        cand_if.candidate_value <= v;
        do @(posedge i_clk); while (cand_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // called at the falling edge after an acceptance; withdraws the request first
    task automatic wait_drained();
        cand_if.valid <= 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
    endtask

    initial begin
        int gap;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = draw_gap(recv_burst);
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    initial begin
        cand_if.valid           = 1'b0;
        cand_if.candidate_value = '0;
        res_if.ready            = 1'b0;
        i_rst_n                 = 1'b0;
        cycle_cnt               = 0;
        send_burst              = 1'b0;
        recv_burst              = 1'b0;
        hold_req                = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (corner_vals[k]) send_cand(corner_vals[k]);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            if (ph == 0) begin
                send_burst = 1'b1;
                recv_burst = 1'b1;
            end
            if (ph == 2) begin
                // output stalled for a long stretch while candidates keep coming
                send_burst = 1'b1;
                hold_req   = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) send_cand(pick_cand(ph == 2));
            if (ph == 5 || $urandom_range(0, 2) == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
